// ===== hdl/mcpg_pkg.sv =====
// Package for the motor command plausibility guard.
// Holds widths, register indexes, the configuration struct and the sequencer state type.
// No dependencies.
package mcpg_pkg;

   localparam int MaxMotors  = 8;
   localparam int CmdWidth   = 16;
   localparam int IdxWidth   = $clog2(MaxMotors);
   localparam int CountWidth = $clog2(MaxMotors + 1);
   localparam int SumWidth   = CmdWidth + IdxWidth;
   localparam int FracWidth  = 16;
   localparam int ProdWidth  = SumWidth + CmdWidth;
   localparam int DevWidth   = CmdWidth + CountWidth;
   localparam int ThrWidth   = DevWidth + FracWidth;
   localparam int TimeWidth  = 64;
   localparam int DelayWidth = 32;
   localparam int DataWidth  = 32;
   localparam int AddrWidth  = 5;
   localparam int RegIdxWidth = 3;
   localparam int OutIdxWidth = 3;

   localparam logic [RegIdxWidth-1:0] RegMitigationEnable = 3'd0;
   localparam logic [RegIdxWidth-1:0] RegMinArmedOutput   = 3'd1;
   localparam logic [RegIdxWidth-1:0] RegAsymmetryMinAbs  = 3'd2;
   localparam logic [RegIdxWidth-1:0] RegAsymmetryFrac    = 3'd3;
   localparam logic [RegIdxWidth-1:0] RegConfirmTime      = 3'd4;
   localparam logic [RegIdxWidth-1:0] RegRecoveryTime     = 3'd5;

   typedef struct packed {
      logic                  mitigation_enable;
      logic [CmdWidth-1:0]   min_armed_output;
      logic [CmdWidth-1:0]   asymmetry_min_abs;
      logic [FracWidth-1:0]  asymmetry_fraction;
      logic [DelayWidth-1:0] confirm_time_us;
      logic [DelayWidth-1:0] recovery_time_us;
   } cfg_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_NEAR,
      SEQ_FRAC,
      SEQ_FLOOR,
      SEQ_THR,
      SEQ_DEV_MUL,
      SEQ_DEV_CMP,
      SEQ_DEBOUNCE,
      SEQ_EMIT
   } seq_state_type;

endpackage

// ===== hdl/mcpg_csr.sv =====
// Configuration registers of the plausibility guard behind an APB-style port.
// Depends on mcpg_pkg.
module mcpg_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mcpg_pkg::AddrWidth-1:0] paddr,
   input  logic [mcpg_pkg::DataWidth-1:0] pwdata,
   output logic [mcpg_pkg::DataWidth-1:0] prdata,
   output logic                          pready,
   output mcpg_pkg::cfg_type             cfg
);
   import mcpg_pkg::*;

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic [RegIdxWidth-1:0] reg_idx;
   logic                   wr_en;

   assign reg_idx = paddr[AddrWidth-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            RegMitigationEnable: cfg_in.mitigation_enable  = pwdata[0];
            RegMinArmedOutput:   cfg_in.min_armed_output   = pwdata[CmdWidth-1:0];
            RegAsymmetryMinAbs:  cfg_in.asymmetry_min_abs  = pwdata[CmdWidth-1:0];
            RegAsymmetryFrac:    cfg_in.asymmetry_fraction = pwdata[FracWidth-1:0];
            RegConfirmTime:      cfg_in.confirm_time_us    = pwdata[DelayWidth-1:0];
            RegRecoveryTime:     cfg_in.recovery_time_us   = pwdata[DelayWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         RegMitigationEnable: prdata = DataWidth'(cfg_ff.mitigation_enable);
         RegMinArmedOutput:   prdata = DataWidth'(cfg_ff.min_armed_output);
         RegAsymmetryMinAbs:  prdata = DataWidth'(cfg_ff.asymmetry_min_abs);
         RegAsymmetryFrac:    prdata = DataWidth'(cfg_ff.asymmetry_fraction);
         RegConfirmTime:      prdata = DataWidth'(cfg_ff.confirm_time_us);
         RegRecoveryTime:     prdata = DataWidth'(cfg_ff.recovery_time_us);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mitigation_enable  <= 1'b1;
         cfg_ff.min_armed_output   <= CmdWidth'(50);
         cfg_ff.asymmetry_min_abs  <= CmdWidth'(200);
         cfg_ff.asymmetry_fraction <= FracWidth'(32768);
         cfg_ff.confirm_time_us    <= DelayWidth'(100000);
         cfg_ff.recovery_time_us   <= DelayWidth'(1000000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/mcpg_mul.sv =====
// Shared multiplier of the plausibility guard with a registered product.
// Depends on mcpg_pkg.
module mcpg_mul (
   input  logic                          clock,
   input  logic [mcpg_pkg::SumWidth-1:0]  op_a,
   input  logic [mcpg_pkg::CmdWidth-1:0]  op_b,
   output logic [mcpg_pkg::ProdWidth-1:0] product
);
   import mcpg_pkg::*;

   logic [ProdWidth-1:0] product_ff;
   logic [ProdWidth-1:0] product_in;

   assign product_in = ProdWidth'(op_a) * ProdWidth'(op_b);
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// ===== hdl/mcpg_debounce.sv =====
// Timed debounce of the anomaly flag: confirm and recovery timers on microsecond time.
// Depends on mcpg_pkg.
module mcpg_debounce (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,
   input  logic                          anomaly,
   input  logic [mcpg_pkg::TimeWidth-1:0] now_us,
   input  mcpg_pkg::cfg_type             cfg,
   output logic                          flag_active
);
   import mcpg_pkg::*;

   logic                 flag_ff, flag_in;
   logic                 anom_pend_ff, anom_pend_in;
   logic                 rec_pend_ff, rec_pend_in;
   logic [TimeWidth-1:0] anom_since_ff, anom_since_in;
   logic [TimeWidth-1:0] rec_since_ff, rec_since_in;
   logic [TimeWidth-1:0] anom_start;
   logic [TimeWidth-1:0] anom_elapsed;
   logic [TimeWidth-1:0] rec_elapsed;

   assign anom_start   = anom_pend_ff ? anom_since_ff : now_us;
   assign anom_elapsed = now_us - anom_start;
   assign rec_elapsed  = now_us - rec_since_ff;
   assign flag_active  = flag_ff;

   always_comb begin
      flag_in       = flag_ff;
      anom_pend_in  = anom_pend_ff;
      rec_pend_in   = rec_pend_ff;
      anom_since_in = anom_since_ff;
      rec_since_in  = rec_since_ff;
      if (update) begin
         if (anomaly) begin
            rec_pend_in   = 1'b0;
            anom_pend_in  = 1'b1;
            anom_since_in = anom_start;
            if (!flag_ff && anom_elapsed >= TimeWidth'(cfg.confirm_time_us)) begin
               flag_in = 1'b1;
            end
         end else begin
            anom_pend_in = 1'b0;
            if (flag_ff) begin
               if (!rec_pend_ff) begin
                  rec_since_in = now_us;
                  rec_pend_in  = 1'b1;
               end else if (rec_elapsed >= TimeWidth'(cfg.recovery_time_us)) begin
                  flag_in     = 1'b0;
                  rec_pend_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff       <= 1'b0;
         anom_pend_ff  <= 1'b0;
         rec_pend_ff   <= 1'b0;
         anom_since_ff <= '0;
         rec_since_ff  <= '0;
      end else begin
         flag_ff       <= flag_in;
         anom_pend_ff  <= anom_pend_in;
         rec_pend_ff   <= rec_pend_in;
         anom_since_ff <= anom_since_in;
         rec_since_ff  <= rec_since_in;
      end
   end

endmodule

// ===== hdl/motor_command_plausibility_guard_top.sv =====
// Top level of the motor command plausibility guard: motor stores, sequencer, result port.
// Depends on mcpg_pkg, mcpg_csr, mcpg_mul and mcpg_debounce.
//
// Usage: present one transaction per active motor on the req_ ports with start high while
// busy is low. A transaction without req_last_motor is stored and busy stays low. Motors
// beyond eight are dropped, but a dropped last motor still ends the set. The transaction
// with req_last_motor raises busy. The sequencer then drives one shared multiplier: the
// states NEAR, FRAC, FLOOR and THR for the near-zero test and the threshold, DEV_MUL and
// DEV_CMP per motor for the deviation test (skipped when mitigation is off, the set is
// empty or the mean is near zero), and DEBOUNCE for the debounce update. Results for the
// n stored motors then follow back to back, each marked by rsp_valid, the last with
// rsp_last_result; busy falls after it.
// The receiver cannot stall: each result is present for exactly one cycle.
// Reset (synchronous, active high) loads the register defaults, empties the motor set
// and clears the debounced flag and its timers. Registers sit at byte address 4*i on the
// APB-style port; write them only while the block is idle (the block does not enforce it).
module motor_command_plausibility_guard_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [mcpg_pkg::CmdWidth-1:0]    req_motor_command,
   input  logic [mcpg_pkg::CmdWidth-1:0]    req_legitimate_command,
   input  logic                             req_last_motor,
   input  logic                             req_vehicle_armed,
   input  logic                             req_vehicle_airborne,
   input  logic [mcpg_pkg::TimeWidth-1:0]   req_now_us,
   output logic                             rsp_valid,
   output logic [mcpg_pkg::OutIdxWidth-1:0] rsp_motor_index,
   output logic [mcpg_pkg::CmdWidth-1:0]    rsp_corrected_command,
   output logic                             rsp_last_result,
   output logic                             rsp_anomaly_now,
   output logic                             rsp_anomaly_active,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mcpg_pkg::AddrWidth-1:0]   paddr,
   input  logic [mcpg_pkg::DataWidth-1:0]   pwdata,
   output logic [mcpg_pkg::DataWidth-1:0]   prdata,
   output logic                             pready
);
   import mcpg_pkg::*;

   cfg_type cfg;

   seq_state_type state_ff, state_in;

   logic [CmdWidth-1:0]   cmd_store_ff [MaxMotors];
   logic [CmdWidth-1:0]   legit_store_ff [MaxMotors];
   logic [SumWidth-1:0]   sum_ff, sum_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [IdxWidth-1:0]   idx_ff, idx_in;
   logic [MaxMotors-1:0]  restore_ff, restore_in;
   logic                  anomaly_ff, anomaly_in;
   logic                  near_ff, near_in;
   logic [ThrWidth-1:0]   thr_ff, thr_in;
   logic                  armed_ff, airborne_ff;
   logic [TimeWidth-1:0]  now_ff;

   logic                  accept;
   logic                  store_en;
   logic                  idx_is_last;
   logic                  finish;
   logic [SumWidth-1:0]   mul_a;
   logic [CmdWidth-1:0]   mul_b;
   logic [ProdWidth-1:0]  product;
   logic                  deb_update;
   logic                  flag_active;
   logic [ThrWidth-1:0]   floor_s;
   logic [DevWidth-1:0]   scaled;
   logic [DevWidth-1:0]   sum_ext;
   logic [DevWidth-1:0]   dev;
   logic [CmdWidth-1:0]   cmd_rd_ff;
   logic [CmdWidth-1:0]   legit_rd_ff;

   mcpg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mcpg_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   mcpg_debounce u_debounce (
      .clock       (clock),
      .reset       (reset),
      .update      (deb_update),
      .anomaly     (anomaly_ff),
      .now_us      (now_ff),
      .cfg         (cfg),
      .flag_active (flag_active)
   );

   assign busy        = (state_ff != SEQ_IDLE);
   assign accept      = start & ~busy;
   assign store_en    = accept & (count_ff < CountWidth'(MaxMotors));
   assign idx_is_last = (CountWidth'(idx_ff) + CountWidth'(1)) == count_ff;
   assign floor_s     = {product[DevWidth-1:0], FracWidth'(0)};
   assign scaled      = product[DevWidth-1:0];
   assign sum_ext     = DevWidth'(sum_ff);
   assign dev         = (scaled >= sum_ext) ? (scaled - sum_ext) : (sum_ext - scaled);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE:  if (accept && req_last_motor) state_in = SEQ_NEAR;
         SEQ_NEAR:  state_in = SEQ_FRAC;
         SEQ_FRAC:  state_in = SEQ_FLOOR;
         SEQ_FLOOR: state_in = SEQ_THR;
         SEQ_THR: begin
            if (!cfg.mitigation_enable || count_ff == '0 || near_ff) begin
               state_in = SEQ_DEBOUNCE;
            end else begin
               state_in = SEQ_DEV_MUL;
            end
         end
         SEQ_DEV_MUL: state_in = SEQ_DEV_CMP;
         SEQ_DEV_CMP: state_in = idx_is_last ? SEQ_DEBOUNCE : SEQ_DEV_MUL;
         SEQ_DEBOUNCE: state_in = (count_ff == '0) ? SEQ_IDLE : SEQ_EMIT;
         SEQ_EMIT:  if (idx_is_last) state_in = SEQ_IDLE;
         default:   state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      mul_a      = SumWidth'(count_ff);
      mul_b      = cmd_rd_ff;
      deb_update = 1'b0;
      rsp_valid  = 1'b0;
      finish     = 1'b0;
      case (state_ff)
         SEQ_NEAR:  mul_b = cfg.min_armed_output;
         SEQ_FRAC: begin
            mul_a = sum_ff;
            mul_b = cfg.asymmetry_fraction;
         end
         SEQ_FLOOR: mul_b = cfg.asymmetry_min_abs;
         SEQ_DEBOUNCE: begin
            deb_update = 1'b1;
            finish     = (count_ff == '0);
         end
         SEQ_EMIT: begin
            rsp_valid = 1'b1;
            finish    = idx_is_last;
         end
         default: ;
      endcase
   end

   assign rsp_motor_index       = OutIdxWidth'(idx_ff);
   assign rsp_corrected_command = restore_ff[idx_ff] ? legit_rd_ff : cmd_rd_ff;
   assign rsp_last_result       = idx_is_last;
   assign rsp_anomaly_now       = anomaly_ff;
   assign rsp_anomaly_active    = flag_active;

   always_comb begin
      sum_in     = sum_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      restore_in = restore_ff;
      anomaly_in = anomaly_ff;
      near_in    = near_ff;
      thr_in     = thr_ff;
      if (store_en) begin
         sum_in   = sum_ff + SumWidth'(req_motor_command);
         count_in = count_ff + CountWidth'(1);
      end
      case (state_ff)
         SEQ_IDLE: begin
            if (accept && req_last_motor) begin
               restore_in = '0;
               anomaly_in = 1'b0;
               idx_in     = '0;
            end
         end
         SEQ_FRAC:  near_in = ProdWidth'(sum_ff) < product;
         SEQ_FLOOR: thr_in  = ThrWidth'(product);
         SEQ_THR: begin
            if (floor_s > thr_ff) thr_in = floor_s;
            if (cfg.mitigation_enable && count_ff != '0 && near_ff
                && armed_ff && airborne_ff) begin
               restore_in = '1;
               anomaly_in = 1'b1;
            end
         end
         SEQ_DEV_CMP: begin
            if ({dev, FracWidth'(0)} > thr_ff) begin
               restore_in[idx_ff] = 1'b1;
               anomaly_in         = 1'b1;
            end
            idx_in = idx_is_last ? '0 : idx_ff + IdxWidth'(1);
         end
         SEQ_EMIT: idx_in = idx_ff + IdxWidth'(1);
         default: ;
      endcase
      if (finish) begin
         sum_in   = '0;
         count_in = '0;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         sum_ff   <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      restore_ff <= restore_in;
      anomaly_ff <= anomaly_in;
      near_ff    <= near_in;
      thr_ff     <= thr_in;
      if (store_en) begin
         cmd_store_ff[count_ff[IdxWidth-1:0]]   <= req_motor_command;
         legit_store_ff[count_ff[IdxWidth-1:0]] <= req_legitimate_command;
      end
      cmd_rd_ff   <= cmd_store_ff[idx_in];
      legit_rd_ff <= legit_store_ff[idx_in];
      if (accept && req_last_motor) begin
         armed_ff    <= req_vehicle_armed;
         airborne_ff <= req_vehicle_airborne;
         now_ff      <= req_now_us;
      end
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result strobe outside a busy period");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_motor) |=> !busy)
      else $error("non-final transaction made the block busy");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |=> (!busy && !rsp_valid))
      else $error("block stayed busy after the final result");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_result) |=> rsp_valid)
      else $error("gap in the result burst");

endmodule
